>>> rtl/assert_macros.svh
// Assertion helpers used by mrsp_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/mrsp_pkg.sv
`default_nettype none

package mrsp_pkg;

    localparam logic [7:0] STATUS_BIT      = 8'h80;
    localparam logic [7:0] SYSTEM_BASE     = 8'hF0;
    localparam logic [7:0] REALTIME_BASE   = 8'hF8;
    localparam logic [6:0] STOP_NOTE_RESET = 7'h6C;

    localparam logic [3:0] KIND_PROG_CHANGE = 4'hC;
    localparam logic [3:0] KIND_CHAN_PRESS  = 4'hD;

    // byte handed from the input stage to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_byte_xfer;

    typedef struct packed {
        logic       stop_seen;
        logic [6:0] second_data;
        logic [6:0] first_data;
        logic [7:0] msg_status;
    } t_msg;

    function automatic logic is_one_byte_kind(input logic [7:0] status);
        return (status[7:4] == KIND_PROG_CHANGE) || (status[7:4] == KIND_CHAN_PRESS);
    endfunction

endpackage

`default_nettype wire

>>> rtl/mrsp_in_stage.sv
`default_nettype none

module mrsp_in_stage (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  wire                    i_advance,
    output mrsp_pkg::t_byte_xfer   o_item
);
    import mrsp_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    assign s_axis_tready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid && !i_advance;
        if (s_axis_tvalid && s_axis_tready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte <= s_axis_tdata;
        end
    end

    assign o_item = {r_valid, r_byte};

endmodule

`default_nettype wire

>>> rtl/mrsp_core.sv
`default_nettype none
`include "assert_macros.svh"

module mrsp_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [6:0]             i_cfg_wdata,
    input  mrsp_pkg::t_byte_xfer   i_item,
    output logic                   o_advance,
    input  wire                    i_out_ready,
    output logic                   o_out_valid,
    output mrsp_pkg::t_msg         o_msg
);
    import mrsp_pkg::*;

    logic [6:0] r_stop_note;
    logic [7:0] r_rs;
    logic       r_have;
    logic [6:0] r_held;
    logic       r_out_valid;
    t_msg       r_out;

    logic [7:0] n_rs;
    logic       n_have;
    logic [6:0] n_held;
    logic       emit;
    t_msg       n_out;
    logic       take;
    logic [7:0] b;

    assign o_advance = !r_out_valid || i_out_ready;
    assign take      = i_item.valid && o_advance;
    assign b         = i_item.data;

    always_comb begin
        n_rs   = r_rs;
        n_have = r_have;
        n_held = r_held;
        emit   = 1'b0;
        n_out.msg_status  = r_rs;
        n_out.first_data  = b[6:0];
        n_out.second_data = 7'd0;
        if ((b & STATUS_BIT) != 8'd0) begin
            if (b < REALTIME_BASE) begin
                n_rs   = (b >= SYSTEM_BASE) ? 8'd0 : b;
                n_have = 1'b0;
                n_held = 7'd0;
            end
        end else if (r_rs != 8'd0) begin
            if (is_one_byte_kind(r_rs)) begin
                emit = 1'b1;
            end else if (!r_have) begin
                n_held = b[6:0];
                n_have = 1'b1;
            end else begin
                emit              = 1'b1;
                n_out.first_data  = r_held;
                n_out.second_data = b[6:0];
                n_have            = 1'b0;
                n_held            = 7'd0;
            end
        end
        n_out.stop_seen = (n_out.first_data == r_stop_note);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_note <= STOP_NOTE_RESET;
            r_rs        <= 8'd0;
            r_have      <= 1'b0;
            r_held      <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stop_note <= i_cfg_wdata;
            end
            if (take) begin
                r_rs   <= n_rs;
                r_have <= n_have;
                r_held <= n_held;
            end
            if (o_advance) begin
                r_out_valid <= take && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_msg       = r_out;

    `ASSERT_NEVER(a_rs_channel_only, i_clk, i_rst_n, (r_rs != 8'd0) && (r_rs < STATUS_BIT || r_rs >= SYSTEM_BASE))
    `ASSERT_NEVER(a_have_two_byte, i_clk, i_rst_n, r_have && ((r_rs == 8'd0) || is_one_byte_kind(r_rs)))
    `ASSERT_PROP(a_one_byte_second_zero, i_clk, i_rst_n, (r_out_valid && is_one_byte_kind(r_out.msg_status)) |-> (r_out.second_data == 7'd0))
    `ASSERT_PROP(a_stall_holds, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))

endmodule

`default_nettype wire

>>> rtl/midi_running_status_parser.sv
// A result reaches the master side through the input register and the result
// register, after the transfer of the data byte that completes its message.
// Throughput: one byte per cycle; input register and result register each
// hold one item, so backpressure stalls the input only when both are full.
// Reset (synchronous, active low): no running status, no pending data byte,
// stop_note set to 108.
`default_nettype none

module midi_running_status_parser (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [6:0]  i_cfg_wdata,     // stop_note
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [7:0] msg_status, [14:8] first_data,
                                         // [21:15] second_data, [23:22] zero
    output logic        m_axis_tuser     // [0] stop_seen
);
    import mrsp_pkg::*;

    t_byte_xfer item;
    logic       advance;
    t_msg       msg;

    mrsp_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_advance     (advance),
        .o_item        (item)
    );

    mrsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .o_advance   (advance),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_msg       (msg)
    );

    assign m_axis_tdata = {2'b00, msg.second_data, msg.first_data, msg.msg_status};
    assign m_axis_tuser = msg.stop_seen;

endmodule

`default_nettype wire

>>> tb/sv/midi_running_status_parser_test.sv
`timescale 1ns / 1ps

module midi_running_status_parser_test;

    import mrsp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam logic [7:0]  NO_STATUS      = 8'h00;
    localparam logic [7:0]  LAST_CHANNEL   = 8'hEF;
    localparam logic [7:0]  LAST_TWO_BYTE  = 8'hBF;
    localparam logic [7:0]  LAST_BYTE      = 8'hFF;

    localparam logic [1:0] READY_ALWAYS = 2'd0;
    localparam logic [1:0] READY_RANDOM = 2'd1;
    localparam logic [1:0] READY_SPARSE = 2'd2;
    localparam logic [1:0] READY_MOSTLY = 2'd3;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [6:0]  i_cfg_wdata   = 7'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    midi_running_status_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as predicted
    logic [7:0] cur_status    = NO_STATUS;
    logic       first_pending = 1'b0;
    logic [6:0] first_held    = 7'd0;
    logic [6:0] stop_note_cfg = STOP_NOTE_RESET;

    t_msg        expected_msgs [$];
    logic [7:0]  pending_bytes [$];
    logic [7:0]  directed_bytes [$] = '{
        8'h55, 8'h80, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h9F, 8'h6C, 8'h01, 8'h90,
        8'h3C, 8'hA1, 8'h3C, 8'h40, 8'hC5, 8'h7F, 8'h00, 8'hDA, 8'h6C, 8'hE0,
        8'h12, 8'hFE, 8'h34, 8'hF7, 8'h12
    };

    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned msgs_checked   = 0;
    int unsigned stops_checked  = 0;
    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    int unsigned burst_left     = 1;
    int unsigned gap_left       = 0;
    logic        send_hold      = 1'b0;
    logic [7:0]  stall_cnt      = 8'd0;
    logic [1:0]  stall_mode     = READY_ALWAYS;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch @%0t: %s got %0h want %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic push_expected_msg(input logic [6:0] d1, input logic [6:0] d2);
        t_msg msg;
        msg.msg_status  = cur_status;
        msg.first_data  = d1;
        msg.second_data = d2;
        msg.stop_seen   = (d1 == stop_note_cfg);
        expected_msgs.push_back(msg);
    endtask

    task automatic predict_byte(input logic [7:0] rx);
        if ((rx & STATUS_BIT) != 8'd0) begin
            if (rx >= REALTIME_BASE)
                return;
            cur_status    = (rx >= SYSTEM_BASE) ? NO_STATUS : rx;
            first_pending = 1'b0;
            first_held    = 7'd0;
        end else if (cur_status != NO_STATUS) begin
            if (is_one_byte_kind(cur_status)) begin
                push_expected_msg(rx[6:0], 7'd0);
            end else if (!first_pending) begin
                first_held    = rx[6:0];
                first_pending = 1'b1;
            end else begin
                push_expected_msg(first_held, rx[6:0]);
                first_pending = 1'b0;
                first_held    = 7'd0;
            end
        end
    endtask

    function automatic void queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endfunction

    function automatic logic [7:0] pick_data();
        logic [6:0] d;
        d = ($urandom_range(0, 5) == 0) ? stop_note_cfg : 7'($urandom_range(0, 127));
        return {1'b0, d};
    endfunction

    function automatic logic [7:0] pick_realtime();
        return 8'($urandom_range(REALTIME_BASE, LAST_BYTE));
    endfunction

    // mostly well-formed running-status runs, some system, real-time and stray bytes
    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned done_items;
        int unsigned sel;
        logic [7:0]  status;
        logic        one_byte;
        done_items = 0;
        while (done_items < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                status   = 8'($urandom_range(STATUS_BIT, LAST_CHANNEL));
                one_byte = is_one_byte_kind(status);
                queue_byte(status);
                done_items++;
                repeat ($urandom_range(1, 6)) begin
                    queue_byte(pick_data());
                    done_items++;
                    if (!one_byte) begin
                        if ($urandom_range(0, 15) == 0)
                            queue_byte(pick_realtime());
                        queue_byte(pick_data());
                        done_items++;
                    end
                end
            end else if (sel < 87) begin
                queue_byte(8'($urandom_range(SYSTEM_BASE, REALTIME_BASE - 1)));
                done_items++;
            end else if (sel < 93) begin
                queue_byte(pick_realtime());
            end else if (sel < 97) begin
                queue_byte(8'($urandom_range(0, 127)));
                done_items++;
            end else begin
                queue_byte(8'($urandom_range(STATUS_BIT, LAST_TWO_BYTE)));
                queue_byte(pick_data());
                done_items += 2;
            end
        end
    endtask

    task automatic wait_idle();
        while (!(bytes_accepted == bytes_queued && expected_msgs.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_stop_note(input logic [6:0] note);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= note;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        stop_note_cfg = note;
    endtask

    always @(posedge i_clk) begin : drive
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata);
                bytes_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (send_hold || pending_bytes.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : receive
        t_msg got;
        t_msg want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[21:0]};
                if (expected_msgs.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(m_axis_tdata), 0);
                end else begin
                    want = expected_msgs.pop_front();
                    if (got.msg_status != want.msg_status)
                        report_mismatch("msg_status", 32'(got.msg_status),
                                        32'(want.msg_status));
                    if (got.first_data != want.first_data)
                        report_mismatch("first_data", 32'(got.first_data),
                                        32'(want.first_data));
                    if (got.second_data != want.second_data)
                        report_mismatch("second_data", 32'(got.second_data),
                                        32'(want.second_data));
                    if (got.stop_seen != want.stop_seen)
                        report_mismatch("stop_seen", 32'(got.stop_seen),
                                        32'(want.stop_seen));
                    msgs_checked++;
                    if (want.stop_seen)
                        stops_checked++;
                end
            end
            stall_cnt <= stall_cnt + 8'd1;
            if (stall_cnt[5:0] == 6'h3F)
                stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
                READY_ALWAYS: m_axis_tready <= 1'b1;
                READY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_axis_tready <= (stall_cnt[3:0] == 4'd0);
                default:      m_axis_tready <= (stall_cnt[2:0] != 3'd0);
            endcase
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [6:0] rand_note;
        rand_note = 7'($urandom_range(1, 126));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of stop_note in force
        foreach (directed_bytes[k])
            queue_byte(directed_bytes[k]);
        queue_random_traffic(240);
        wait_idle();

        write_stop_note(7'd0);
        queue_random_traffic(240);
        wait_idle();

        write_stop_note(7'd127);
        queue_random_traffic(240);
        wait_idle();

        // hold the sender mid-stream until the output drains
        write_stop_note(rand_note);
        queue_random_traffic(240);
        while (pending_bytes.size() > 120)
            @(posedge i_clk);
        send_hold <= 1'b1;
        @(posedge i_clk);
        while (s_axis_tvalid || expected_msgs.size() != 0)
            @(posedge i_clk);
        send_hold <= 1'b0;
        wait_idle();

        $display("covered %0d bytes under stop_note 108, 0, 127 and %0d", bytes_accepted,
                 rand_note);
        $display("compared %0d messages, %0d of them with the stop flag, %0d mismatches",
                 msgs_checked, stops_checked, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/mrsp_pkg.sv
rtl/mrsp_in_stage.sv
rtl/mrsp_core.sv
rtl/midi_running_status_parser.sv
tb/sv/midi_running_status_parser_test.sv
